/* rtl/timed_interval_active_entry_lookup_macros.svh */
// assertion macros for the timed interval active entry lookup
// expects i_clk and i_rst_n in the including module
`ifndef TIMED_INTERVAL_ACTIVE_ENTRY_LOOKUP_MACROS_SVH
`define TIMED_INTERVAL_ACTIVE_ENTRY_LOOKUP_MACROS_SVH

`ifndef SYNTH
`define TIAEL_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TIAEL_CHECK_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> expr) \
        else $error(msg);
`else
`define TIAEL_CHECK(lbl, prop, msg)
`define TIAEL_CHECK_NEXT(lbl, cond, expr, msg)
`endif

`endif

/* rtl/tiael_pkg.sv */
// shared constants and types of the timed interval active entry lookup
// no dependencies
package tiael_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int TIME_BITS_DEF   = 24;

    localparam int FIELD_TIME_W  = 24;
    localparam int FIELD_INDEX_W = 8;
    localparam int LEAD_W        = 16;
    localparam int LINE_COUNT_W  = 9;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 80;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_LINE_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEAD_IN    = 1'd1;

    localparam logic [LEAD_W-1:0] LEAD_IN_RST = 16'd800;

    typedef struct packed {
        logic                     done;
        logic                     hit;
        logic [FIELD_INDEX_W-1:0] index;
    } t_srch_sts;

endpackage

/* rtl/tiael_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module tiael_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/tiael_search.sv */
// binary search sequencer with one shared time comparator
// depends on tiael_pkg; drives the read port of tiael_ram
module tiael_search import tiael_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_ENTRIES),
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [TIME_BITS-1:0]   i_time,
    input  logic [LEAD_W-1:0]      i_lead,
    input  logic [CNT_W-1:0]       i_count,
    input  logic                   i_ack,
    output logic                   o_busy,
    output logic [IDX_W-1:0]       o_raddr,
    input  logic [2*TIME_BITS-1:0] i_rdata,
    output t_srch_sts              o_sts
);
    localparam int LW = TIME_BITS + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SRCH = 5'b00010,
        S_END  = 5'b00100,
        S_NEXT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                   r_state;
    logic [TIME_BITS-1:0]     r_time;
    logic [LW-1:0]            r_tlead;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_lo;
    logic [CNT_W-1:0]         r_hx;
    logic [IDX_W-1:0]         r_mid;
    logic                     r_hit;
    logic [FIELD_INDEX_W-1:0] r_idx;

    logic [TIME_BITS-1:0] w_rd_start;
    logic [TIME_BITS-1:0] w_rd_end;
    logic [LW-1:0]        w_cmp_a;
    logic [LW-1:0]        w_cmp_b;
    logic                 w_le;
    logic [CNT_W-1:0]     n_lo;
    logic [CNT_W-1:0]     n_hx;
    logic [IDX_W-1:0]     n_mid;
    logic                 w_more;
    logic [IDX_W-1:0]     w_first_mid;

    assign w_rd_start = i_rdata[TIME_BITS-1:0];
    assign w_rd_end   = i_rdata[2*TIME_BITS-1:TIME_BITS];

    // shared comparator: a <= b
    assign w_cmp_a = {1'b0, (r_state == S_END) ? w_rd_end : w_rd_start};
    assign w_cmp_b = (r_state == S_NEXT) ? r_tlead : {1'b0, r_time};
    assign w_le    = w_cmp_a <= w_cmp_b;

    // half-open range [lo, hx)
    assign n_lo   = w_le ? CNT_W'(r_mid) + CNT_W'(1) : r_lo;
    assign n_hx   = w_le ? r_hx : CNT_W'(r_mid);
    assign w_more = n_lo < n_hx;
    assign n_mid  = IDX_W'(n_lo + ((n_hx - n_lo - CNT_W'(1)) >> 1));
    assign w_first_mid = IDX_W'((i_count - CNT_W'(1)) >> 1);

    always_comb begin
        o_raddr = '0;
        case (r_state)
            S_IDLE: o_raddr = w_first_mid;
            S_SRCH: begin
                if (w_more) begin
                    o_raddr = n_mid;
                end else if (n_lo == '0) begin
                    o_raddr = '0;
                end else begin
                    o_raddr = IDX_W'(n_lo - CNT_W'(1));
                end
            end
            S_END:   o_raddr = IDX_W'(r_lo);
            default: o_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= (i_count == '0) ? S_DONE : S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (!w_more) begin
                        r_state <= (n_lo == '0) ? S_NEXT : S_END;
                    end
                end
                S_END: begin
                    if (w_le && (r_lo < r_count)) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_NEXT: r_state <= S_DONE;
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_time  <= i_time;
                r_tlead <= {1'b0, i_time} + LW'(i_lead);
                r_count <= i_count;
                r_lo    <= '0;
                r_hx    <= i_count;
                r_mid   <= w_first_mid;
                r_hit   <= 1'b0;
                r_idx   <= '0;
            end
            S_SRCH: begin
                r_lo  <= n_lo;
                r_hx  <= n_hx;
                r_mid <= n_mid;
            end
            S_END: begin
                // entry still running, or nothing after it: hold it
                r_hit <= 1'b1;
                r_idx <= FIELD_INDEX_W'(r_lo - CNT_W'(1));
            end
            S_NEXT: begin
                if (w_le) begin
                    r_hit <= 1'b1;
                    r_idx <= FIELD_INDEX_W'(r_lo);
                end else if (r_lo == '0) begin
                    r_hit <= 1'b0;
                    r_idx <= '0;
                end else begin
                    r_hit <= 1'b1;
                    r_idx <= FIELD_INDEX_W'(r_lo - CNT_W'(1));
                end
            end
            default: begin
                r_hit <= r_hit;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.hit   = r_hit;
    assign o_sts.index = r_idx;
endmodule

/* rtl/timed_interval_active_entry_lookup.sv */
// top level of the timed interval active entry lookup
// depends on tiael_pkg, tiael_ram, tiael_search and the assertion macro header
// A write request (tuser 1) stores one entry's start and end time;
// an index at or beyond MAX_ENTRIES is dropped. A query request (tuser 0) binary
// searches the first line_count entries for the last start at or before the query
// time and returns one result: the running entry, the upcoming one inside the
// lead-in window, the held finished one, or none. The entry memory has one read
// port and the search issues one probe per cycle through it. s_axis_tready is low
// from the time a query is taken until its result moves to the output register.
// A finished result waits in an output register, so the next request is taken while
// the result is still pending; a search that finishes while that register is still
// held waits until it is taken.
// Configuration must be written through i_cfg_* only while no request is in flight;
// the block itself does not enforce this.
`include "timed_interval_active_entry_lookup_macros.svh"

module timed_interval_active_entry_lookup import tiael_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // query_time_ms[23:0], entry_index[31:24], entry_start_ms[55:32], entry_end_ms[79:56]
    input  logic [IN_DATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  logic [0:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // active_index[7:0]
    output logic [FIELD_INDEX_W-1:0] m_axis_tdata,
    // active_valid[0]
    output logic [0:0]               m_axis_tuser,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata
);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [LINE_COUNT_W-1:0]  r_line_count;
    logic [LEAD_W-1:0]        r_lead_in;
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic [FIELD_INDEX_W-1:0] r_out_idx;

    logic                     w_accept;
    logic                     w_start;
    logic                     w_wr;
    logic [FIELD_INDEX_W-1:0] w_in_idx;
    logic [TIME_BITS-1:0]     w_q_time;
    logic [TIME_BITS-1:0]     w_e_start;
    logic [TIME_BITS-1:0]     w_e_end;
    logic [CNT_W-1:0]         w_count;
    logic                     w_busy;
    logic [IDX_W-1:0]         w_raddr;
    logic [2*TIME_BITS-1:0]   w_rdata;
    logic                     w_ack;
    t_srch_sts                w_sts;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_in_idx  = s_axis_tdata[31:24];
    assign w_q_time  = TIME_BITS'(s_axis_tdata[23:0]);
    assign w_e_start = TIME_BITS'(s_axis_tdata[55:32]);
    assign w_e_end   = TIME_BITS'(s_axis_tdata[79:56]);
    assign w_start   = w_accept && (s_axis_tuser[0] == FUNC_QUERY);
    assign w_wr      = w_accept && (s_axis_tuser[0] == FUNC_WRITE)
                       && ({24'd0, w_in_idx} < 32'(MAX_ENTRIES));

    // line count saturates at the table depth
    assign w_count = ({23'd0, r_line_count} > 32'(MAX_ENTRIES))
                     ? CNT_W'(MAX_ENTRIES) : CNT_W'(r_line_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_lead_in    <= LEAD_IN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LINE_COUNT: r_line_count <= i_cfg_wdata[LINE_COUNT_W-1:0];
                REG_LEAD_IN:    r_lead_in    <= i_cfg_wdata[LEAD_W-1:0];
                default:        r_lead_in    <= r_lead_in;
            endcase
        end
    end

    tiael_ram #(
        .WIDTH (2 * TIME_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (IDX_W'(w_in_idx)),
        .i_wdata ({w_e_end, w_e_start}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tiael_search #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TIME_BITS   (TIME_BITS)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_time  (w_q_time),
        .i_lead  (r_lead_in),
        .i_count (w_count),
        .i_ack   (w_ack),
        .o_busy  (w_busy),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata),
        .o_sts   (w_sts)
    );

    assign s_axis_tready = !w_busy;
    assign w_ack = w_sts.done && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out_hit <= w_sts.hit;
            r_out_idx <= w_sts.index;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_idx;
    assign m_axis_tuser[0] = r_out_hit;

    `TIAEL_CHECK(a_none_zero_index, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "none result with nonzero index")
    `TIAEL_CHECK_NEXT(a_query_starts, w_start, w_busy, "query request did not start a search")
    `TIAEL_CHECK_NEXT(a_write_no_search, w_accept && (s_axis_tuser[0] == FUNC_WRITE), !w_busy, "write request started a search")
    `TIAEL_CHECK(a_result_from_search, $rose(m_axis_tvalid) |-> $past(w_sts.done), "result appeared without a finished search")
endmodule

/* dv/testbench.sv */
// self-checking testbench of timed_interval_active_entry_lookup: a queue-fed driver,
// a randomly stalling receiver and a scoreboard that predicts each query answer
// depends on tiael_pkg and the rtl of timed_interval_active_entry_lookup
module testbench;
    import tiael_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int MAX_REPORTS   = 200;
    localparam logic [FIELD_TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        logic                     func;
        logic [FIELD_TIME_W-1:0]  qtime;
        logic [FIELD_INDEX_W-1:0] idx;
        logic [FIELD_TIME_W-1:0]  st_ms;
        logic [FIELD_TIME_W-1:0]  end_ms;
    } lookup_req_t;

    typedef struct {
        logic                     valid;
        logic [FIELD_INDEX_W-1:0] index;
    } active_pick_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata  = '0;
    logic [0:0]               s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [FIELD_INDEX_W-1:0] m_axis_tdata;
    logic [0:0]               m_axis_tuser;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]    i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_wdata   = '0;

    timed_interval_active_entry_lookup DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the entry table and registers, updated as requests are taken
    logic [FIELD_TIME_W-1:0] shadow_start [MAX_ENTRIES_DEF];
    logic [FIELD_TIME_W-1:0] shadow_end   [MAX_ENTRIES_DEF];
    logic [LINE_COUNT_W-1:0] shadow_line_count = '0;
    logic [LEAD_W-1:0]       shadow_lead_in    = LEAD_IN_RST;

    // what the stimulus side has already queued, used to aim query times
    logic [FIELD_TIME_W-1:0] plan_start [MAX_ENTRIES_DEF];
    logic [FIELD_TIME_W-1:0] plan_end   [MAX_ENTRIES_DEF];
    int loaded_upto = 0;
    int issued      = 0;

    lookup_req_t  pending_reqs [$];
    active_pick_t expected_picks [$];
    lookup_req_t  cur_req;

    int err_count     = 0;
    int cycles        = 0;
    bit drv_busy      = 1'b0;
    bit src_took      = 1'b0;
    bit sink_took     = 1'b0;
    bit src_calm      = 1'b0;
    bit sink_calm     = 1'b0;
    bit sink_hold_req = 1'b0;
    int src_wait      = 0;
    int sink_wait     = 0;
    int hold_left     = 0;

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic bit near_start(input logic [FIELD_TIME_W-1:0] st,
                                      input logic [FIELD_TIME_W-1:0] t);
        logic [31:0] reach;
        reach = 32'(t) + 32'(shadow_lead_in);
        return 32'(st) <= reach;
    endfunction

    function automatic active_pick_t predict_active(input logic [FIELD_TIME_W-1:0] t);
        int n;
        int lo;
        int hi;
        int mid;
        int cand;
        int pick;
        active_pick_t r;
        n    = (int'(shadow_line_count) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF
                                                           : int'(shadow_line_count);
        lo   = 0;
        hi   = n - 1;
        cand = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_start[mid] <= t) begin
                cand = mid;
                lo   = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        pick = -1;
        if (cand >= 0) begin
            if (t < shadow_end[cand])
                pick = cand;
            else if (cand + 1 < n && near_start(shadow_start[cand + 1], t))
                pick = cand + 1;
            else
                pick = cand;
        end else if (n > 0 && near_start(shadow_start[0], t)) begin
            pick = 0;
        end
        r.valid = (pick >= 0);
        r.index = (pick >= 0) ? FIELD_INDEX_W'(pick) : '0;
        return r;
    endfunction

    // driver: one request at a time, random gap before each
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (src_took) begin
                src_took = 1'b0;
                drv_busy = 1'b0;
                src_wait = draw_gap(src_calm);
            end
            if (!drv_busy && src_wait > 0) begin
                src_wait--;
            end else if (!drv_busy && pending_reqs.size() != 0) begin
                cur_req  = pending_reqs.pop_front();
                drv_busy = 1'b1;
            end
            s_axis_tvalid <= drv_busy;
            if (drv_busy) begin
                s_axis_tdata <= {cur_req.end_ms, cur_req.st_ms, cur_req.idx, cur_req.qtime};
                s_axis_tuser <= cur_req.func;
            end
        end
    end

    // receiver: random stall after each result, long hold-off on request
    always @(negedge i_clk) begin
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_took) begin
                sink_took = 1'b0;
                sink_wait = draw_gap(sink_calm);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // scoreboard: check results, then record taken requests
    always @(posedge i_clk) begin
        active_pick_t want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sink_took = 1'b1;
                if (expected_picks.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result expected none actual valid %0d index %0d",
                                 $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_picks.pop_front();
                    if (m_axis_tuser[0] !== want.valid) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: active_valid expected %0d actual %0d",
                                     $time, want.valid, m_axis_tuser[0]);
                    end
                    if (m_axis_tdata !== want.index) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: active_index expected %0d actual %0d",
                                     $time, want.index, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                src_took = 1'b1;
                if (cur_req.func == FUNC_WRITE) begin
                    shadow_start[cur_req.idx] = cur_req.st_ms;
                    shadow_end[cur_req.idx]   = cur_req.end_ms;
                end else begin
                    expected_picks.push_back(predict_active(cur_req.qtime));
                end
            end
        end
    end

    task automatic queue_query(input logic [FIELD_TIME_W-1:0] t);
        lookup_req_t r;
        r.func   = FUNC_QUERY;
        r.qtime  = t;
        r.idx    = FIELD_INDEX_W'($urandom());
        r.st_ms  = FIELD_TIME_W'($urandom());
        r.end_ms = FIELD_TIME_W'($urandom());
        pending_reqs.push_back(r);
        issued++;
    endtask

    task automatic queue_entry(input int idx, input logic [FIELD_TIME_W-1:0] st,
                               input logic [FIELD_TIME_W-1:0] en);
        lookup_req_t r;
        r.func   = FUNC_WRITE;
        r.qtime  = FIELD_TIME_W'($urandom());
        r.idx    = FIELD_INDEX_W'(idx);
        r.st_ms  = st;
        r.end_ms = en;
        plan_start[idx] = st;
        plan_end[idx]   = en;
        pending_reqs.push_back(r);
        issued++;
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || drv_busy || expected_picks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_DATA_W'(value);
        if (addr == REG_LINE_COUNT)
            shadow_line_count = LINE_COUNT_W'(value);
        else
            shadow_lead_in = LEAD_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // entries 0..k-1, sorted by start unless scrambled
    task automatic load_table(input int k, input bit scrambled);
        longint cursor;
        longint len;
        longint st;
        int i;
        cursor = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215 - k * 7000)
                                             : $urandom_range(0, 3000);
        for (i = 0; i < k; i++) begin
            if (scrambled) begin
                st  = $urandom_range(0, 16777215);
                len = $urandom_range(0, 5000);
            end else begin
                st  = cursor;
                len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3000);
                cursor = st + len + $urandom_range(0, 4000);
                if ($urandom_range(0, 7) == 0)
                    cursor = st + len / 2;
            end
            queue_entry(i, FIELD_TIME_W'(st), FIELD_TIME_W'(st + len));
        end
        if (k > loaded_upto)
            loaded_upto = k;
    endtask

    task automatic queue_queries(input int count, input int span);
        longint tl;
        longint lead;
        int j;
        int c;
        lead = shadow_lead_in;
        for (c = 0; c < count; c++) begin
            j = $urandom_range(0, span - 1);
            case ($urandom_range(0, 11))
                0:       tl = $urandom_range(0, 16777215);
                1:       tl = $urandom_range(0, 1) ? longint'(TIME_MAX) : 0;
                2:       tl = plan_start[j];
                3:       tl = plan_end[j];
                4:       tl = longint'(plan_end[j]) - 1;
                5:       tl = longint'(plan_start[j]) - lead;
                6:       tl = longint'(plan_start[j]) - lead - 1;
                default: tl = longint'(plan_start[j]) - lead - 200
                              + $urandom_range(0, int'(lead) + 6000);
            endcase
            if (tl < 0)
                tl = 0;
            if (tl > longint'(TIME_MAX))
                tl = TIME_MAX;
            if ($urandom_range(0, 11) == 0)
                queue_entry($urandom_range(0, loaded_upto - 1),
                            FIELD_TIME_W'($urandom()), FIELD_TIME_W'($urandom()));
            queue_query(FIELD_TIME_W'(tl));
        end
    endtask

    initial begin
        int ph;
        int k;
        int lc;
        int start_issued;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then a small sorted table under the reset lead-in
        queue_query(24'd5000);
        queue_entry(0, 24'd1000, 24'd2000);
        queue_entry(1, 24'd2500, 24'd3000);
        queue_entry(2, 24'd5000, 24'd6000);
        queue_entry(3, 24'd16777000, TIME_MAX);
        queue_entry(255, 24'd0, TIME_MAX);
        loaded_upto = 4;
        settle();
        write_reg(REG_LINE_COUNT, 4);
        queue_query(24'd0);
        queue_query(24'd200);
        queue_query(24'd1500);
        queue_query(24'd1999);
        queue_query(24'd2000);
        queue_query(24'd2500);
        queue_query(24'd3500);
        queue_query(24'd4200);
        queue_query(24'd16777000);
        queue_query(TIME_MAX);
        settle();
        write_reg(REG_LEAD_IN, 0);
        queue_query(24'd2000);
        queue_query(24'd2500);
        settle();
        write_reg(REG_LEAD_IN, 65535);
        queue_query(24'd0);
        queue_query(24'd3000);
        settle();

        start_issued = issued;
        ph = 1;
        while (issued - start_issued < RANDOM_ITEMS) begin
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       write_reg(REG_LEAD_IN, $urandom_range(0, 1) ? 0 : 65535);
                1:       write_reg(REG_LEAD_IN, $urandom_range(0, 65535));
                default: write_reg(REG_LEAD_IN, $urandom_range(0, 3000));
            endcase
            if (ph == 2 || ph == 7) begin
                load_table(MAX_ENTRIES_DEF, 1'b0);
                settle();
                write_reg(REG_LINE_COUNT, MAX_ENTRIES_DEF);
                queue_queries(30, MAX_ENTRIES_DEF);
                settle();
                write_reg(REG_LINE_COUNT, (ph == 2) ? 511 : $urandom_range(257, 510));
                queue_queries(30, MAX_ENTRIES_DEF);
            end else begin
                k = $urandom_range(1, 16);
                load_table(k, $urandom_range(0, 4) == 0);
                settle();
                lc = k;
                if ($urandom_range(0, 3) == 0)
                    lc = $urandom_range(0, loaded_upto);
                if (loaded_upto == MAX_ENTRIES_DEF && $urandom_range(0, 5) == 0)
                    lc = $urandom_range(257, 511);
                write_reg(REG_LINE_COUNT, lc);
                if (ph == 1) begin
                    // receiver holds off while back-to-back queries pile up
                    src_calm = 1'b1;
                    @(posedge i_clk);
                    sink_hold_req = 1'b1;
                    queue_queries(40, k);
                end else begin
                    queue_queries($urandom_range(30, 60), k);
                end
            end
            settle();
            ph++;
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
